// File: rtl/sfs_pkg.sv
// Shared command codes, register indexes and sequencer states of the frame sequencer.
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_SEEK   = 3'd4,
        CMD_SELECT = 3'd5
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SWEEP,
        ST_CHK_HI,
        ST_MOD,
        ST_BRD,
        ST_BCMP,
        ST_BSUB,
        ST_CHK_LO,
        ST_FCHK,
        ST_FADD,
        ST_DONE
    } t_state;

endpackage

// File: rtl/sfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sfs_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module sfs_mod #(
    parameter int DVD_W = 25,
    parameter int DVS_W = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_acc;

    logic [DVS_W:0]   sh;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] acc_nx;

    always_comb begin
        sh     = {r_acc, r_dvd[DVD_W-1]};
        diff   = sh - {1'b0, r_dvs};
        ge     = (sh >= {1'b0, r_dvs});
        acc_nx = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_acc <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_acc <= acc_nx;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_acc;

endmodule

// File: rtl/sprite_frame_sequencer.sv
// sprite_frame_sequencer: sprite frame timer, frame times held in a one-port-read RAM.
// Load, stop, select: o_valid 2 cycles after the transfer; start: 3. Tick: 4, seek: 7,
// plus 2 per frame stepped, plus DVD_W+1 (26) for a whole-cycle skip through the remainder unit,
// plus min(frame_count, MAX_FRAMES)+2 for a RAM period sweep after a load or frame_count write.
// One item at a time: busy stays high until o_valid, which lasts one cycle; no stall.
// Reset (synchronous, active low): frame 0, time left 0, stopped, frame_count 0, loop on.
`timescale 1ns / 1ps

module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 64,
    parameter int TIME_BITS  = 24,
    localparam int IDX_W = $clog2(MAX_FRAMES),
    localparam int CNT_W = $clog2(MAX_FRAMES + 1),
    localparam int DEL_W = TIME_BITS + 1,
    localparam int REM_W = TIME_BITS + 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CNT_W-1:0]                  i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [sfs_pkg::CMD_W-1:0]         i_cmd,
    input  logic [IDX_W-1:0]                  i_frame_index,
    input  logic signed [DEL_W-1:0]           i_time_delta,
    input  logic [TIME_BITS-1:0]              i_frame_time,
    output logic                              o_valid,
    output logic [IDX_W-1:0]                  o_current_frame,
    output logic                              o_playing,
    output logic signed [REM_W-1:0]           o_time_left
);

    localparam int PER_W = TIME_BITS + CNT_W;
    localparam int CW    = PER_W + 2;
    localparam int DVD_W = REM_W - 1;

    localparam logic signed [CW-1:0] REM_MAX_C = {{(CW-REM_W+1){1'b0}}, {(REM_W-1){1'b1}}};
    localparam logic signed [CW-1:0] REM_MIN_C = {{(CW-REM_W+1){1'b1}}, {(REM_W-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE_C     = {{(CW-1){1'b0}}, 1'b1};

    function automatic logic signed [REM_W-1:0] f_sat(input logic signed [CW-1:0] x);
        if (x > REM_MAX_C) begin
            f_sat = REM_MAX_C[REM_W-1:0];
        end else if (x < REM_MIN_C) begin
            f_sat = REM_MIN_C[REM_W-1:0];
        end else begin
            f_sat = x[REM_W-1:0];
        end
    endfunction

    function automatic logic signed [CW-1:0] f_ft(input logic [TIME_BITS-1:0] v);
        if (v == '0) begin
            f_ft = ONE_C;
        end else begin
            f_ft = $signed({{(CW-TIME_BITS){1'b0}}, v});
        end
    endfunction

    sfs_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]        r_count;
    logic                    r_loop;
    logic [IDX_W-1:0]        r_frame, n_frame;
    logic signed [REM_W-1:0] r_rem, n_rem;
    logic                    r_running, n_running;
    logic                    r_valid, n_valid;
    logic [PER_W-1:0]        r_period, n_period;
    logic                    r_per_ok, n_per_ok;
    logic [CNT_W-1:0]        r_sw, n_sw;
    logic                    r_sw_vld, n_sw_vld;
    logic                    r_is_seek, n_is_seek;
    logic                    r_fwd_stop, n_fwd_stop;
    logic                    r_mod_hi, n_mod_hi;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [TIME_BITS-1:0]    ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [TIME_BITS-1:0]    ram_rdata;

    logic                    mod_start;
    logic [DVD_W-1:0]        mod_dvd;
    logic                    mod_done;
    logic [PER_W-1:0]        mod_rem;

    logic                    accept;
    logic [CNT_W-1:0]        act_n;
    logic signed [CW-1:0]    rem_x, per_x, per2_x, t_x, neg_x, hi_x, d_x, mrem_x;
    logic [CNT_W-1:0]        frm_inc;
    logic                    wrap;
    logic [IDX_W-1:0]        frm_nxt, frm_dec, frm_fix;
    logic                    sweep_end, go_mod_hi, go_mod_lo, back_step, skip_en;

    sfs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sfs_mod #(
        .DVD_W (DVD_W),
        .DVS_W (PER_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (r_period),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign busy   = (r_state != sfs_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        act_n     = (r_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : r_count;
        rem_x     = CW'(r_rem);
        d_x       = CW'(i_time_delta);
        per_x     = $signed({2'b00, r_period});
        per2_x    = $signed({1'b0, r_period, 1'b0});
        t_x       = f_ft(ram_rdata);
        neg_x     = -rem_x - ONE_C;
        hi_x      = rem_x - per2_x - ONE_C;
        mrem_x    = $signed({2'b00, mod_rem});
        frm_inc   = CNT_W'(r_frame) + CNT_W'(1);
        wrap      = (frm_inc >= act_n);
        frm_nxt   = wrap ? '0 : frm_inc[IDX_W-1:0];
        frm_dec   = (r_frame == '0) ? IDX_W'(act_n - CNT_W'(1)) : r_frame - IDX_W'(1);
        frm_fix   = (CNT_W'(r_frame) >= act_n) ? '0 : r_frame;
        sweep_end = (r_sw >= act_n) && !r_sw_vld;
        skip_en   = r_is_seek || r_loop;
        go_mod_hi = (rem_x > per2_x);
        go_mod_lo = skip_en && (rem_x < 0) && (neg_x >= per_x);
        back_step = (rem_x > t_x);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfs_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (sfs_pkg::t_cmd'(i_cmd))
                        sfs_pkg::CMD_START: begin
                            n_state = (act_n != '0) ? sfs_pkg::ST_START : sfs_pkg::ST_DONE;
                        end
                        sfs_pkg::CMD_TICK: begin
                            if (act_n != '0 && r_running) begin
                                n_state = r_per_ok ? sfs_pkg::ST_CHK_LO : sfs_pkg::ST_SWEEP;
                            end else begin
                                n_state = sfs_pkg::ST_DONE;
                            end
                        end
                        sfs_pkg::CMD_SEEK: begin
                            if (act_n != '0) begin
                                n_state = r_per_ok ? sfs_pkg::ST_CHK_HI : sfs_pkg::ST_SWEEP;
                            end else begin
                                n_state = sfs_pkg::ST_DONE;
                            end
                        end
                        default: n_state = sfs_pkg::ST_DONE;
                    endcase
                end
            end
            sfs_pkg::ST_START: n_state = sfs_pkg::ST_DONE;
            sfs_pkg::ST_SWEEP: begin
                if (sweep_end) begin
                    n_state = r_is_seek ? sfs_pkg::ST_CHK_HI : sfs_pkg::ST_CHK_LO;
                end
            end
            sfs_pkg::ST_CHK_HI: n_state = go_mod_hi ? sfs_pkg::ST_MOD : sfs_pkg::ST_BRD;
            sfs_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_state = r_mod_hi ? sfs_pkg::ST_BRD : sfs_pkg::ST_FCHK;
                end
            end
            sfs_pkg::ST_BRD:    n_state = sfs_pkg::ST_BCMP;
            sfs_pkg::ST_BCMP:   n_state = back_step ? sfs_pkg::ST_BSUB : sfs_pkg::ST_CHK_LO;
            sfs_pkg::ST_BSUB:   n_state = sfs_pkg::ST_BCMP;
            sfs_pkg::ST_CHK_LO: n_state = go_mod_lo ? sfs_pkg::ST_MOD : sfs_pkg::ST_FCHK;
            sfs_pkg::ST_FCHK: begin
                if (rem_x < 0) begin
                    n_state = (wrap && r_fwd_stop) ? sfs_pkg::ST_DONE : sfs_pkg::ST_FADD;
                end else begin
                    n_state = sfs_pkg::ST_DONE;
                end
            end
            sfs_pkg::ST_FADD: n_state = sfs_pkg::ST_FCHK;
            sfs_pkg::ST_DONE: n_state = sfs_pkg::ST_IDLE;
            default:          n_state = sfs_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_frame    = r_frame;
        n_rem      = r_rem;
        n_running  = r_running;
        n_valid    = 1'b0;
        n_period   = r_period;
        n_per_ok   = r_per_ok;
        n_sw       = r_sw;
        n_sw_vld   = r_sw_vld;
        n_is_seek  = r_is_seek;
        n_fwd_stop = r_fwd_stop;
        n_mod_hi   = r_mod_hi;
        ram_we     = 1'b0;
        ram_waddr  = i_frame_index;
        ram_wdata  = i_frame_time;
        ram_re     = 1'b0;
        ram_raddr  = r_frame;
        mod_start  = 1'b0;
        mod_dvd    = neg_x[DVD_W-1:0];
        unique case (r_state)
            sfs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_sw     = '0;
                    n_sw_vld = 1'b0;
                    if (!r_per_ok) begin
                        n_period = '0;
                    end
                    unique case (sfs_pkg::t_cmd'(i_cmd))
                        sfs_pkg::CMD_LOAD: begin
                            ram_we   = (CNT_W'(i_frame_index) < CNT_W'(MAX_FRAMES));
                            n_per_ok = 1'b0;
                        end
                        sfs_pkg::CMD_START: begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                        end
                        sfs_pkg::CMD_STOP: begin
                            n_running = 1'b0;
                        end
                        sfs_pkg::CMD_TICK: begin
                            if (act_n != '0 && r_running) begin
                                n_frame    = frm_fix;
                                n_rem      = f_sat(rem_x - d_x);
                                n_is_seek  = 1'b0;
                                n_fwd_stop = !r_loop;
                            end
                        end
                        sfs_pkg::CMD_SEEK: begin
                            if (act_n != '0) begin
                                n_frame    = frm_fix;
                                n_rem      = f_sat(rem_x - d_x);
                                n_is_seek  = 1'b1;
                                n_fwd_stop = 1'b0;
                            end
                        end
                        sfs_pkg::CMD_SELECT: begin
                            if (CNT_W'(i_frame_index) < act_n) begin
                                n_frame = i_frame_index;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sfs_pkg::ST_START: begin
                n_frame   = '0;
                n_rem     = f_sat(t_x);
                n_running = 1'b1;
            end
            sfs_pkg::ST_SWEEP: begin
                ram_re    = (r_sw < act_n);
                ram_raddr = r_sw[IDX_W-1:0];
                n_sw_vld  = (r_sw < act_n);
                if (r_sw < act_n) begin
                    n_sw = r_sw + CNT_W'(1);
                end
                if (r_sw_vld) begin
                    n_period = r_period + t_x[PER_W-1:0];
                end
                if (sweep_end) begin
                    n_per_ok = 1'b1;
                end
            end
            sfs_pkg::ST_CHK_HI: begin
                if (go_mod_hi) begin
                    mod_start = 1'b1;
                    mod_dvd   = hi_x[DVD_W-1:0];
                    n_mod_hi  = 1'b1;
                end
            end
            sfs_pkg::ST_MOD: begin
                if (mod_done) begin
                    if (r_mod_hi) begin
                        n_rem = f_sat(per_x + ONE_C + mrem_x);
                    end else begin
                        n_rem = f_sat(-ONE_C - mrem_x);
                    end
                end
            end
            sfs_pkg::ST_BRD: begin
                ram_re = 1'b1;
            end
            sfs_pkg::ST_BCMP: begin
                if (back_step) begin
                    n_frame   = frm_dec;
                    ram_re    = 1'b1;
                    ram_raddr = frm_dec;
                end
            end
            sfs_pkg::ST_BSUB: begin
                n_rem = f_sat(rem_x - t_x);
            end
            sfs_pkg::ST_CHK_LO: begin
                if (go_mod_lo) begin
                    mod_start = 1'b1;
                    n_mod_hi  = 1'b0;
                end
            end
            sfs_pkg::ST_FCHK: begin
                if (rem_x < 0) begin
                    if (wrap && r_fwd_stop) begin
                        n_frame   = '0;
                        n_running = 1'b0;
                    end else begin
                        n_frame   = frm_nxt;
                        ram_re    = 1'b1;
                        ram_raddr = frm_nxt;
                    end
                end
            end
            sfs_pkg::ST_FADD: begin
                n_rem = f_sat(rem_x + t_x);
            end
            sfs_pkg::ST_DONE: begin
                n_valid = 1'b1;
            end
            default: begin
            end
        endcase
        if (i_cfg_we && i_cfg_index == sfs_pkg::CFG_FRAME_COUNT) begin
            n_per_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sfs_pkg::ST_IDLE;
            r_count   <= '0;
            r_loop    <= 1'b1;
            r_frame   <= '0;
            r_rem     <= '0;
            r_running <= 1'b0;
            r_valid   <= 1'b0;
            r_per_ok  <= 1'b0;
            r_sw_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_frame   <= n_frame;
            r_rem     <= n_rem;
            r_running <= n_running;
            r_valid   <= n_valid;
            r_per_ok  <= n_per_ok;
            r_sw_vld  <= n_sw_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sfs_pkg::CFG_FRAME_COUNT: r_count <= i_cfg_data;
                    sfs_pkg::CFG_LOOP_ENABLE: r_loop  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_period   <= n_period;
        r_sw       <= n_sw;
        r_is_seek  <= n_is_seek;
        r_fwd_stop <= n_fwd_stop;
        r_mod_hi   <= n_mod_hi;
    end

    assign o_valid         = r_valid;
    assign o_current_frame = r_frame;
    assign o_playing       = r_running;
    assign o_time_left     = r_rem;

endmodule
